// ===== rtl/ffrx_pkg.sv =====
`default_nettype none
package ffrx_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned RESULT_W    = 3 * WORD_W + BYTE_W;

    typedef logic [4:0]             frame_idx_t;
    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Register map
    localparam cfg_index_t CFG_HEADER_BYTE  = cfg_index_t'(0);
    localparam cfg_index_t CFG_CHECK_ENABLE = cfg_index_t'(1);

    localparam byte_t HEADER_RESET = byte_t'(8'h42);

    // Frame positions (byte_index holds the position of the next frame byte)
    localparam frame_idx_t IDX_HUNT       = frame_idx_t'(0);
    localparam frame_idx_t IDX_FIRST_DATA = frame_idx_t'(1);
    localparam frame_idx_t IDX_YAW_FIRST  = frame_idx_t'(3);
    localparam frame_idx_t IDX_YAW_LAST   = frame_idx_t'(6);
    localparam frame_idx_t IDX_PITCH_LAST = frame_idx_t'(10);
    localparam frame_idx_t IDX_DEPTH_LAST = frame_idx_t'(14);
    localparam frame_idx_t IDX_FLAG       = frame_idx_t'(15);
    localparam frame_idx_t IDX_CHECK      = frame_idx_t'(16);

endpackage
`default_nettype wire

// ===== rtl/fixed_frame_receiver_sum_check.sv =====
`default_nettype none
// The check byte is held in the input register, and its result is registered onto
// m_tvalid and m_tdata when that byte is processed.
// Throughput: one byte per cycle; an input byte stalls only when it is a check byte
// whose result would overwrite an earlier result that has not yet been taken.
// Reset (aresetn low, synchronous): hunting for a header, sums and words cleared,
// header_byte = 0x42, check_enable = 1, no result pending.
module fixed_frame_receiver_sum_check (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Byte stream in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire ffrx_pkg::byte_t               s_tdata,   // [7:0] rx_byte
    // Frame results out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ffrx_pkg::RESULT_W-1:0]      m_tdata,   // [31:0] yaw_bits,
                                                          // [63:32] pitch_bits,
                                                          // [95:64] depth_bits,
                                                          // [103:96] flag_byte
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire ffrx_pkg::cfg_index_t          cfg_index,
    input  wire ffrx_pkg::byte_t               cfg_data
);
    import ffrx_pkg::*;

    byte_t      header_reg;
    logic       check_en_reg;

    logic       in_valid_reg;
    byte_t      in_byte_reg;

    frame_idx_t byte_index_reg, byte_index_next;
    byte_t      sum_reg, sum_next;
    word_t      yaw_reg, yaw_next;
    word_t      pitch_reg, pitch_next;
    word_t      depth_reg, depth_next;
    byte_t      flag_reg, flag_next;

    logic                m_valid_reg;
    logic [RESULT_W-1:0] m_data_reg;

    logic hunting;
    logic at_check;
    logic emit;
    logic out_full;
    logic proc_fire;
    logic s_fire;

    assign hunting   = (byte_index_reg == IDX_HUNT) || (byte_index_reg > IDX_CHECK);
    assign at_check  = (byte_index_reg == IDX_CHECK);
    assign emit      = at_check && (!check_en_reg || (sum_reg == in_byte_reg));
    assign out_full  = m_valid_reg && !m_tready;
    // Hold the input byte only when it would produce a result with nowhere to go
    assign proc_fire = in_valid_reg && !(emit && out_full);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        byte_index_next = byte_index_reg;
        sum_next        = sum_reg;
        yaw_next        = yaw_reg;
        pitch_next      = pitch_reg;
        depth_next      = depth_reg;
        flag_next       = flag_reg;
        priority if (hunting) begin
            if (in_byte_reg == header_reg) begin
                sum_next        = in_byte_reg;
                byte_index_next = IDX_FIRST_DATA;
            end else begin
                byte_index_next = IDX_HUNT;
            end
        end else if (at_check) begin
            byte_index_next = IDX_HUNT;
        end else begin
            if (byte_index_reg != IDX_FLAG) begin
                sum_next = sum_reg + in_byte_reg;
            end
            // Shift each byte in from the top: little-endian assembly
            priority if (byte_index_reg >= IDX_YAW_FIRST && byte_index_reg <= IDX_YAW_LAST) begin
                yaw_next = {in_byte_reg, yaw_reg[WORD_W-1:BYTE_W]};
            end else if (byte_index_reg > IDX_YAW_LAST
                         && byte_index_reg <= IDX_PITCH_LAST) begin
                pitch_next = {in_byte_reg, pitch_reg[WORD_W-1:BYTE_W]};
            end else if (byte_index_reg > IDX_PITCH_LAST
                         && byte_index_reg <= IDX_DEPTH_LAST) begin
                depth_next = {in_byte_reg, depth_reg[WORD_W-1:BYTE_W]};
            end else if (byte_index_reg == IDX_FLAG) begin
                flag_next = in_byte_reg;
            end else begin
                flag_next = flag_reg;
            end
            byte_index_next = byte_index_reg + frame_idx_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg     <= HEADER_RESET;
            check_en_reg   <= 1'b1;
            in_valid_reg   <= 1'b0;
            byte_index_reg <= IDX_HUNT;
            sum_reg        <= '0;
            yaw_reg        <= '0;
            pitch_reg      <= '0;
            depth_reg      <= '0;
            flag_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HEADER_BYTE) begin
                    header_reg <= cfg_data;
                end else if (cfg_index == CFG_CHECK_ENABLE) begin
                    check_en_reg <= cfg_data[0];
                end
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire) begin
                byte_index_reg <= byte_index_next;
                sum_reg        <= sum_next;
                yaw_reg        <= yaw_next;
                pitch_reg      <= pitch_next;
                depth_reg      <= depth_next;
                flag_reg       <= flag_next;
            end
            if (proc_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
        if (proc_fire && emit) begin
            m_data_reg <= {flag_reg, depth_reg, pitch_reg, yaw_reg};
        end
    end

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg <= IDX_CHECK)
        else $error("frame position out of range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(proc_fire && at_check))
        else $error("result raised without a check byte");

    a_header_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && hunting && in_byte_reg == header_reg)
        |=> byte_index_reg == IDX_FIRST_DATA)
        else $error("header byte did not start a frame");

    a_no_check_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && at_check && !check_en_reg) |=> m_valid_reg)
        else $error("frame dropped with check disabled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== bench/frame_result_checker.sv =====
module frame_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire ffrx_pkg::byte_t                 s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [ffrx_pkg::RESULT_W-1:0]   m_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire ffrx_pkg::cfg_index_t            cfg_index,
    input  wire ffrx_pkg::byte_t                 cfg_data,
    output int                                   fail_count,
    output int                                   frames_pending,
    output int                                   bytes_taken,
    output int                                   results_taken,
    output int                                   frames_refused
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffrx_pkg::*;

    // Lowest field in the lowest bits, as on m_tdata
    typedef struct packed {
        byte_t flag;
        word_t depth;
        word_t pitch;
        word_t yaw;
    } frame_result_t;

    byte_t           hdr_value;
    logic            sum_check_on;
    frame_idx_t      next_pos;
    byte_t           sum_acc;
    word_t           yaw_acc;
    word_t           pitch_acc;
    word_t           depth_acc;
    byte_t           flag_acc;
    frame_result_t   expected_frames[$];
    int              errs;
    int              byte_cnt;
    int              result_cnt;
    int              refuse_cnt;

    initial begin
        errs       = 0;
        byte_cnt   = 0;
        result_cnt = 0;
        refuse_cnt = 0;
    end

    function automatic word_t shift_byte_in(word_t w, byte_t b);
        return {b, w[WORD_W-1:BYTE_W]};
    endfunction

    task automatic clear_model();
        hdr_value    = HEADER_RESET;
        sum_check_on = 1'b1;
        next_pos     = IDX_HUNT;
        sum_acc      = '0;
        yaw_acc      = '0;
        pitch_acc    = '0;
        depth_acc    = '0;
        flag_acc     = '0;
        expected_frames.delete();
    endtask

    task automatic absorb_rx_byte(input byte_t b);
        if (next_pos == IDX_HUNT || next_pos > IDX_CHECK) begin
            if (b == hdr_value) begin
                sum_acc  = b;
                next_pos = IDX_FIRST_DATA;
            end else begin
                next_pos = IDX_HUNT;
            end
        end else if (next_pos < IDX_CHECK) begin
            if (next_pos < IDX_FLAG)
                sum_acc = sum_acc + b;
            if (next_pos >= IDX_YAW_FIRST && next_pos <= IDX_YAW_LAST)
                yaw_acc = shift_byte_in(yaw_acc, b);
            else if (next_pos > IDX_YAW_LAST && next_pos <= IDX_PITCH_LAST)
                pitch_acc = shift_byte_in(pitch_acc, b);
            else if (next_pos > IDX_PITCH_LAST && next_pos <= IDX_DEPTH_LAST)
                depth_acc = shift_byte_in(depth_acc, b);
            else if (next_pos == IDX_FLAG)
                flag_acc = b;
            next_pos = next_pos + 1'b1;
        end else begin
            // check byte: back to hunting whatever the outcome
            next_pos = IDX_HUNT;
            if (sum_check_on && sum_acc != b) begin
                refuse_cnt++;
            end else begin
                expected_frames.push_back('{flag: flag_acc, depth: depth_acc,
                                            pitch: pitch_acc, yaw: yaw_acc});
            end
        end
    endtask

    task automatic compare_result(input frame_result_t got);
        frame_result_t want;
        if (expected_frames.size() == 0) begin
            errs++;
            $display("%0t: unexpected result transfer: expected none, actual %h",
                     $time, got);
            return;
        end
        want = expected_frames.pop_front();
        if (got.yaw !== want.yaw) begin
            errs++;
            $display("%0t: yaw_bits mismatch: expected %h, actual %h",
                     $time, want.yaw, got.yaw);
        end
        if (got.pitch !== want.pitch) begin
            errs++;
            $display("%0t: pitch_bits mismatch: expected %h, actual %h",
                     $time, want.pitch, got.pitch);
        end
        if (got.depth !== want.depth) begin
            errs++;
            $display("%0t: depth_bits mismatch: expected %h, actual %h",
                     $time, want.depth, got.depth);
        end
        if (got.flag !== want.flag) begin
            errs++;
            $display("%0t: flag_byte mismatch: expected %h, actual %h",
                     $time, want.flag, got.flag);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HEADER_BYTE)
                    hdr_value = cfg_data;
                else if (cfg_index == CFG_CHECK_ENABLE)
                    sum_check_on = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                byte_cnt++;
                absorb_rx_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                result_cnt++;
                compare_result(frame_result_t'(m_tdata));
            end
        end
        fail_count     <= errs;
        frames_pending <= expected_frames.size();
        bytes_taken    <= byte_cnt;
        results_taken  <= result_cnt;
        frames_refused <= refuse_cnt;
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ffrx_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PCT      = 24;
    localparam cfg_index_t CFG_UNMAPPED = CFG_CHECK_ENABLE + 1'b1;
    localparam int RANDOM_FILL   = -1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    byte_t                 s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    cfg_index_t            cfg_index = '0;
    byte_t                 cfg_data  = '0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [RESULT_W-1:0] m_tdata;
    wire logic             cfg_ready;

    int    fail_total;
    int    pending_total;
    int    bytes_total;
    int    results_total;
    int    refused_total;
    int    bytes_sent  = 0;
    int    frames_sent = 0;
    bit    idling_on   = 1'b1;
    byte_t hdr_now     = HEADER_RESET;

    fixed_frame_receiver_sum_check u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_result_checker u_frame_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_total),
        .frames_pending (pending_total),
        .bytes_taken    (bytes_total),
        .results_taken  (results_total),
        .frames_refused (refused_total)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // random back-pressure on the result side
    always @(posedge aclk) begin
        m_tready <= idling_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    task automatic send_byte(input byte_t b);
        if (idling_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // fill < 0 gives random payload with the odd header value mixed in
    task automatic send_frame(input byte_t hdr, input bit corrupt, input int fill);
        byte_t b;
        byte_t sum;
        int    pos;
        sum = hdr;
        send_byte(hdr);
        for (pos = IDX_FIRST_DATA; pos <= IDX_DEPTH_LAST; pos++) begin
            if (fill >= 0)
                b = byte_t'(fill);
            else if ($urandom_range(9) == 0)
                b = hdr;
            else
                b = byte_t'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte((fill >= 0) ? byte_t'(fill) : byte_t'($urandom));
        if (corrupt)
            sum = sum ^ byte_t'(1 << $urandom_range(BYTE_W - 1));
        send_byte(sum);
        frames_sent++;
    endtask

    task automatic send_random_traffic(input int n_bytes);
        int start;
        int pick;
        int k;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 5)
                send_frame(hdr_now, 1'b0, 0);
            else if (pick < 10)
                send_frame(hdr_now, 1'b0, 255);
            else if (pick < 70)
                send_frame(hdr_now, 1'b0, RANDOM_FILL);
            else if (pick < 85)
                send_frame(hdr_now, 1'b1, RANDOM_FILL);
            else
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_byte(byte_t'($urandom));
        end
    endtask

    // hold off until every expected result is in and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_total != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input byte_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: stray bytes, extreme payloads, a bad sum, header in payload
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(hdr_now, 1'b0, 0);
        send_frame(hdr_now, 1'b0, 255);
        send_frame(hdr_now, 1'b1, RANDOM_FILL);
        send_frame(hdr_now, 1'b0, hdr_now);
        send_random_traffic(250);
        drain();

        // zero header, check off; unmapped indexes must be ignored
        write_reg(CFG_HEADER_BYTE, 8'h00);
        write_reg(CFG_CHECK_ENABLE, 8'h00);
        write_reg(CFG_UNMAPPED, 8'h5A);
        write_reg(cfg_index_t'('1), 8'hC3);
        hdr_now = 8'h00;
        send_frame(hdr_now, 1'b1, RANDOM_FILL);
        send_random_traffic(280);
        drain();

        // all-ones header, check on through a value with upper bits set
        write_reg(CFG_HEADER_BYTE, 8'hFF);
        write_reg(CFG_CHECK_ENABLE, 8'hFF);
        hdr_now = 8'hFF;
        send_frame(hdr_now, 1'b0, 255);
        send_random_traffic(280);
        drain();

        // random header; bit 0 clear disables the check
        hdr_now = byte_t'($urandom_range(1, 254));
        write_reg(CFG_HEADER_BYTE, hdr_now);
        write_reg(CFG_CHECK_ENABLE, 8'hFE);
        send_random_traffic(280);
        drain();

        // back to defaults with no idling on either side
        write_reg(CFG_HEADER_BYTE, HEADER_RESET);
        write_reg(CFG_CHECK_ENABLE, 8'h01);
        hdr_now   = HEADER_RESET;
        idling_on = 1'b0;
        send_random_traffic(280);
        drain();

        $display("Sent %0d bytes in %0d frames over five register settings;",
                 bytes_sent, frames_sent);
        $display("%0d results compared, %0d frames refused on sum, %0d bytes taken.",
                 results_total, refused_total, bytes_total);
        if (fail_total == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400_000);
        $display("Timeout with %0d results outstanding", pending_total);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
